@@ hdl/qmr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qmr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_W = 32;
	// product after the fraction shift, and the widest sum of four such terms
	localparam int PROD_W = 2 * WORD_W - FRAC_BITS;
	localparam int SUM_W = PROD_W + 2;
	localparam int DATA_IN_W = 8 * WORD_W;
	localparam int DATA_OUT_W = 4 * WORD_W;

	// component order in every vector
	localparam int CX = 0;
	localparam int CY = 1;
	localparam int CZ = 2;
	localparam int CW = 3;

	// operation kinds carried on tuser
	localparam logic KIND_MUL = 1'b0;
	localparam logic KIND_ROT = 1'b1;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// exact product, shifted right rounding toward minus infinity
	function automatic prod_t mul_shift(input word_t x, input word_t y);
		logic signed [2*WORD_W-1:0] p;
		p = x * y;
		return p[2*WORD_W-1:FRAC_BITS];
	endfunction

	// clamp to the signed word range
	function automatic word_t sat_word(input sum_t v);
		if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1])) begin
			return v[WORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

@@ hdl/quaternion_multiply_rotate_unit_core.sv @@
// Quaternion multiply / vector rotate unit, signed Q16.16 on every component.
// Input stream (s_axis): tuser selects the operation, 0 = Hamilton product a*b,
// 1 = rotate vector b.xyz by quaternion a (b.w ignored, result w is zero).
// tdata carries a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, 32 bits each, a_x lowest.
// Output stream (m_axis): tdata carries r_x, r_y, r_z, r_w, r_x lowest, each
// component saturated to the signed 32-bit range.
// An accepted input beat passes through the input register, product bank,
// sums and rotate temporary, second product bank, and final sum and
// saturation into the output register.
// Throughput is one beat per cycle unless the output stalls; every stage holds
// one 32x32 multiply at most per path, so multipliers set the clock, not the rate.
// When the receiver stalls with a beat waiting, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset (arst_n low) empties the pipeline; payload registers are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_multiply_rotate_unit_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	// a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
	input  wire  [qmr_pkg::DATA_IN_W-1:0]   s_axis_tdata,
	// kind
	input  wire                             s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// r_x, r_y, r_z, r_w
	output logic [qmr_pkg::DATA_OUT_W-1:0]  m_axis_tdata
);

	import qmr_pkg::*;

	logic adv;

	logic  v_s1, v_s2, v_s3, v_s4;
	logic  kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	word_t a_s1 [4];
	word_t b_s1 [4];
	word_t a_s2 [4];
	word_t b_s2 [3];
	prod_t p_s2 [4][4];
	word_t a_s3 [3];
	word_t b_s3 [3];
	word_t t_s3 [3];
	word_t aw_s3;
	word_t mr_s3 [4];
	word_t b_s4 [3];
	word_t mr_s4 [4];
	prod_t qw_s4 [3];
	prod_t qa_s4 [3];
	prod_t qb_s4 [3];
	word_t r_s5 [4];

	logic [3:0][WORD_W-1:0] out_pack;

	// stage combinational results
	prod_t p_c [4][4];
	word_t mr_c [4];
	word_t t_c [3];
	prod_t qw_c [3];
	prod_t qa_c [3];
	prod_t qb_c [3];
	word_t rot_c [3];

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 2: all sixteen cross products of a and b
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				p_c[i][j] = mul_shift(a_s1[i], b_s1[j]);
			end
		end
	end

	// stage 3: hamilton sums, and t = 2*cross(a, b) for rotate
	always_comb begin
		mr_c[CX] = sat_word(sum_t'(p_s2[CW][CX]) + sum_t'(p_s2[CX][CW])
			+ sum_t'(p_s2[CY][CZ]) - sum_t'(p_s2[CZ][CY]));
		mr_c[CY] = sat_word(sum_t'(p_s2[CW][CY]) - sum_t'(p_s2[CX][CZ])
			+ sum_t'(p_s2[CY][CW]) + sum_t'(p_s2[CZ][CX]));
		mr_c[CZ] = sat_word(sum_t'(p_s2[CW][CZ]) + sum_t'(p_s2[CX][CY])
			- sum_t'(p_s2[CY][CX]) + sum_t'(p_s2[CZ][CW]));
		mr_c[CW] = sat_word(sum_t'(p_s2[CW][CW]) - sum_t'(p_s2[CX][CX])
			- sum_t'(p_s2[CY][CY]) - sum_t'(p_s2[CZ][CZ]));
		t_c[CX] = sat_word((sum_t'(p_s2[CY][CZ]) - sum_t'(p_s2[CZ][CY])) <<< 1);
		t_c[CY] = sat_word((sum_t'(p_s2[CZ][CX]) - sum_t'(p_s2[CX][CZ])) <<< 1);
		t_c[CZ] = sat_word((sum_t'(p_s2[CX][CY]) - sum_t'(p_s2[CY][CX])) <<< 1);
	end

	// stage 4: a.w*t and the two halves of cross(a, t)
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			qw_c[j] = mul_shift(aw_s3, t_s3[j]);
		end
		qa_c[CX] = mul_shift(a_s3[CY], t_s3[CZ]);
		qb_c[CX] = mul_shift(a_s3[CZ], t_s3[CY]);
		qa_c[CY] = mul_shift(a_s3[CZ], t_s3[CX]);
		qb_c[CY] = mul_shift(a_s3[CX], t_s3[CZ]);
		qa_c[CZ] = mul_shift(a_s3[CX], t_s3[CY]);
		qb_c[CZ] = mul_shift(a_s3[CY], t_s3[CX]);
	end

	// stage 5: v + a.w*t + cross(a, t)
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rot_c[j] = sat_word(sum_t'(b_s4[j]) + sum_t'(qw_s4[j])
				+ (sum_t'(qa_s4[j]) - sum_t'(qb_s4[j])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			m_axis_tvalid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= s_axis_tuser;
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= s_axis_tdata[i*WORD_W +: WORD_W];
				b_s1[i] <= s_axis_tdata[(i+4)*WORD_W +: WORD_W];
			end

			kind_s2 <= kind_s1;
			p_s2 <= p_c;
			a_s2 <= a_s1;
			for (int j = 0; j < 3; j++) begin
				b_s2[j] <= b_s1[j];
			end

			kind_s3 <= kind_s2;
			mr_s3 <= mr_c;
			t_s3 <= t_c;
			aw_s3 <= a_s2[CW];
			for (int j = 0; j < 3; j++) begin
				a_s3[j] <= a_s2[j];
			end
			b_s3 <= b_s2;

			kind_s4 <= kind_s3;
			mr_s4 <= mr_s3;
			b_s4 <= b_s3;
			qw_s4 <= qw_c;
			qa_s4 <= qa_c;
			qb_s4 <= qb_c;

			kind_s5 <= kind_s4;
			if (kind_s4 == KIND_ROT) begin
				for (int j = 0; j < 3; j++) begin
					r_s5[j] <= rot_c[j];
				end
				r_s5[CW] <= '0;
			end else begin
				r_s5 <= mr_s4;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			out_pack[i] = r_s5[i];
		end
	end

	assign m_axis_tdata = out_pack;

`ifndef SYNTHESIS
	// a rotate result never carries a nonzero w
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (kind_s5 == KIND_ROT) |-> (r_s5[CW] == '0))
		else $error("rotate result with nonzero w");

	// an output beat only appears when the last inner stage held one
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v_s4))
		else $error("output beat without a beat in flight");

	// while the output is stalled the inner stages keep their valid bits
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(v_s1) && $stable(v_s2)
			&& $stable(v_s3) && $stable(v_s4))
		else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire
